// ===== design/srr_pkg.sv =====
// Package for the stop-and-wait reorder receiver.
// Packet record, command and result codes, fixed limits. No dependencies.
package srr_pkg;

  localparam int SEQ_W    = 16;
  localparam int BYTES_W  = 11;
  localparam int TAG_W    = 16;
  localparam int NEWEST_W = 17;
  localparam int DROP_W   = 7;
  localparam int KIND_W   = 2;
  localparam int OP_W     = 3;

  localparam logic [DROP_W-1:0] DROP_RESET = 7'd10;
  localparam logic [DROP_W-1:0] DROP_MIN   = 7'd2;
  localparam logic [DROP_W-1:0] DROP_MAX   = 7'd100;

  localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [BYTES_W-1:0] bytes;
    logic [TAG_W-1:0]   tag;
    logic               chan;
    logic               fin;
  } pkt_t;

  localparam int PKT_W = $bits(pkt_t);

  // Commands from the front part to the back part
  localparam logic [OP_W-1:0] OP_WRITE_ACK = 3'd0;
  localparam logic [OP_W-1:0] OP_STORE     = 3'd1;
  localparam logic [OP_W-1:0] OP_FLUSH     = 3'd2;
  localparam logic [OP_W-1:0] OP_CLOSE     = 3'd3;
  localparam logic [OP_W-1:0] OP_DONE      = 3'd4;
  localparam logic [OP_W-1:0] OP_REFUSE    = 3'd5;

  // Result kinds
  localparam logic [KIND_W-1:0] K_WRITE  = 2'd0;
  localparam logic [KIND_W-1:0] K_ACK    = 2'd1;
  localparam logic [KIND_W-1:0] K_REFUSE = 2'd2;
  localparam logic [KIND_W-1:0] K_DONE   = 2'd3;

endpackage

// ===== design/stop_and_wait_reorder_receiver.sv =====
// Stop-and-wait reorder receiver, top level: front, command queue, back.
// The back sequencer handles one queued command at a time, popping the next only
// when it returns to idle; the four-entry queue takes items every cycle while it
// has room. A flush walks the slot store in slot order.
// Reset (rst, synchronous) clears state and slot valid bits; no clearing pass.
module stop_and_wait_reorder_receiver import srr_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [DROP_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [SEQ_W-1:0]   seq_num,
  input  logic [BYTES_W-1:0] byte_count,
  input  logic [TAG_W-1:0]   payload_tag,
  input  logic               chan,
  input  logic               final_flag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  kind,
  output logic [SEQ_W-1:0]   out_seq,
  output logic [BYTES_W-1:0] out_bytes,
  output logic [TAG_W-1:0]   out_tag,
  output logic               out_chan,
  output logic               out_final,
  output logic               run_end
);

  localparam int IW = $clog2(DEPTH);
  localparam int QW = OP_W + IW + PKT_W;

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  logic [OP_W-1:0] cmd_op;
  logic [IW-1:0]   cmd_slot;
  pkt_t            cmd_pkt;
  logic [QW-1:0]   q_wdata;
  logic [QW-1:0]   q_rdata;
  logic [OP_W-1:0] q_op;
  logic [IW-1:0]   q_slot;
  pkt_t            q_pkt;

  assign q_wdata = {cmd_op, cmd_slot, cmd_pkt};
  assign q_op    = q_rdata[QW-1 -: OP_W];
  assign q_slot  = q_rdata[PKT_W +: IW];
  assign q_pkt   = q_rdata[PKT_W-1:0];

  srr_front #(.DEPTH(DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .seq_num     (seq_num),
    .byte_count  (byte_count),
    .payload_tag (payload_tag),
    .chan        (chan),
    .final_flag  (final_flag),
    .q_full      (q_full),
    .push        (push),
    .cmd_op      (cmd_op),
    .cmd_slot    (cmd_slot),
    .cmd_pkt     (cmd_pkt)
  );

  srr_queue #(.WIDTH(QW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  srr_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .pop       (pop),
    .q_op      (q_op),
    .q_slot    (q_slot),
    .q_pkt     (q_pkt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_seq   (out_seq),
    .out_bytes (out_bytes),
    .out_tag   (out_tag),
    .out_chan  (out_chan),
    .out_final (out_final),
    .run_end   (run_end)
  );

endmodule

// ===== design/srr_front.sv =====
// Front part: accepts items, applies the drop pattern and classifies packets.
// Keeps the sequence state and issues one command per kept item. Uses srr_pkg.
module srr_front import srr_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [DROP_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [SEQ_W-1:0]   seq_num,
  input  logic [BYTES_W-1:0] byte_count,
  input  logic [TAG_W-1:0]   payload_tag,
  input  logic               chan,
  input  logic               final_flag,
  input  logic               q_full,
  output logic               push,
  output logic [OP_W-1:0]    cmd_op,
  output logic [IW-1:0]      cmd_slot,
  output pkt_t               cmd_pkt
);

  logic [DROP_W-1:0]   drop_period;
  logic [DROP_W-1:0]   drop_counter;
  logic                holding_mode;
  logic                holding_mode_next;
  logic [NEWEST_W-1:0] newest_seq;
  logic [NEWEST_W-1:0] newest_seq_next;
  logic [SEQ_W-1:0]    missing_seq;
  logic [SEQ_W-1:0]    missing_seq_next;
  logic                finished;
  logic                finished_next;

  logic                accept;
  logic                drop;
  logic [DROP_W-1:0]   eff_period;
  logic [NEWEST_W-1:0] expect_seq;
  logic [NEWEST_W-1:0] seq_ext;
  logic [NEWEST_W-1:0] gap_diff;
  logic [NEWEST_W-1:0] hold_diff;
  logic                gap_ok;
  logic                hold_ok;
  logic                too_big;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  assign eff_period = (drop_period < DROP_MIN) ? DROP_MIN :
                      (drop_period > DROP_MAX) ? DROP_MAX : drop_period;
  assign drop = !finished && !func && (drop_counter >= eff_period - 7'd1);
  assign push = accept && !drop;

  assign cmd_pkt.seq   = seq_num;
  assign cmd_pkt.bytes = byte_count;
  assign cmd_pkt.tag   = payload_tag;
  assign cmd_pkt.chan  = chan;
  assign cmd_pkt.fin   = final_flag;

  assign expect_seq = newest_seq + 17'd1;
  assign seq_ext    = {1'b0, seq_num};
  assign gap_diff   = seq_ext - expect_seq;
  assign hold_diff  = expect_seq - {1'b0, missing_seq};
  assign gap_ok     = (seq_ext > expect_seq) && (gap_diff < NEWEST_W'(DEPTH));
  assign hold_ok    = (seq_ext == expect_seq) && (hold_diff < NEWEST_W'(DEPTH));
  assign too_big    = {5'b0, byte_count} > MAX_PAYLOAD;

  always_comb begin
    cmd_op            = OP_REFUSE;
    cmd_slot          = '0;
    holding_mode_next = holding_mode;
    newest_seq_next   = newest_seq;
    missing_seq_next  = missing_seq;
    finished_next     = finished;
    if (finished) begin
      cmd_op = OP_DONE;
    end else if (func) begin
      cmd_op            = OP_CLOSE;
      finished_next     = 1'b1;
      holding_mode_next = 1'b0;
    end else if (too_big) begin
      cmd_op = OP_REFUSE;
    end else if (!holding_mode) begin
      if (seq_ext == expect_seq) begin
        cmd_op          = OP_WRITE_ACK;
        newest_seq_next = seq_ext;
      end else if (gap_ok) begin
        cmd_op            = OP_STORE;
        cmd_slot          = gap_diff[IW-1:0];
        missing_seq_next  = expect_seq[SEQ_W-1:0];
        newest_seq_next   = seq_ext;
        holding_mode_next = 1'b1;
      end
    end else begin
      if (hold_ok) begin
        cmd_op          = OP_STORE;
        cmd_slot        = hold_diff[IW-1:0];
        newest_seq_next = seq_ext;
      end else if (seq_num == missing_seq) begin
        cmd_op            = OP_FLUSH;
        holding_mode_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_period  <= DROP_RESET;
      drop_counter <= '0;
      holding_mode <= 1'b0;
      newest_seq   <= '1;
      missing_seq  <= '0;
      finished     <= 1'b0;
    end else begin
      if (cfg_we) begin
        drop_period <= cfg_data;
      end
      if (accept && !finished && !func) begin
        drop_counter <= drop ? '0 : drop_counter + 7'd1;
      end
      if (push) begin
        holding_mode <= holding_mode_next;
        newest_seq   <= newest_seq_next;
        missing_seq  <= missing_seq_next;
        finished     <= finished_next;
      end
    end
  end

endmodule

// ===== design/srr_queue.sv =====
// Short command queue between the front and back parts.
// Generic width; depth from srr_pkg.
module srr_queue import srr_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0]  entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/srr_back.sv =====
// Back part: carries out commands, owns the slot store and the output register.
// Walks the store in slot order on a flush or a close. Uses srr_pkg.
module srr_back import srr_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               pop,
  input  logic [OP_W-1:0]    q_op,
  input  logic [IW-1:0]      q_slot,
  input  pkt_t               q_pkt,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  kind,
  output logic [SEQ_W-1:0]   out_seq,
  output logic [BYTES_W-1:0] out_bytes,
  output logic [TAG_W-1:0]   out_tag,
  output logic               out_chan,
  output logic               out_final,
  output logic               run_end
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;

  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

  logic [2:0]        state;
  logic [IW-1:0]     idx;
  pkt_t              cur;
  logic [KIND_W-1:0] tail_kind;
  logic [DEPTH-1:0]  slot_valid;
  pkt_t              slot_store [DEPTH];
  pkt_t              rd_pkt;

  logic              load_ok;
  logic              out_load;
  logic              mem_we;
  logic [IW-1:0]     mem_addr;
  logic              rd_en;

  assign load_ok  = !out_valid || out_ready;
  assign out_load = load_ok &&
                    ((state == S_WR) || (state == S_EMIT) || (state == S_TAIL));
  assign pop      = (state == S_IDLE) && !q_empty;
  assign mem_we   = pop && ((q_op == OP_STORE) || (q_op == OP_FLUSH));
  assign mem_addr = (q_op == OP_FLUSH) ? '0 : q_slot;
  assign rd_en    = (state == S_SCAN) && slot_valid[idx];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_store[mem_addr] <= q_pkt;
    end
    if (rd_en) begin
      rd_pkt <= slot_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_pkt;
            idx <= '0;
            case (q_op)
              OP_WRITE_ACK: begin
                tail_kind <= K_ACK;
                state     <= S_WR;
              end
              OP_STORE: begin
                slot_valid[q_slot] <= 1'b1;
                tail_kind          <= K_ACK;
                state              <= S_TAIL;
              end
              OP_FLUSH: begin
                slot_valid[0] <= 1'b1;
                tail_kind     <= K_ACK;
                state         <= S_SCAN;
              end
              OP_CLOSE: begin
                tail_kind <= K_DONE;
                state     <= S_SCAN;
              end
              OP_DONE: begin
                tail_kind <= K_DONE;
                state     <= S_TAIL;
              end
              default: begin
                tail_kind <= K_REFUSE;
                state     <= S_TAIL;
              end
            endcase
          end
        end
        S_WR: begin
          if (load_ok) begin
            kind      <= K_WRITE;
            out_seq   <= cur.seq;
            out_bytes <= cur.bytes;
            out_tag   <= cur.tag;
            out_chan  <= cur.chan;
            out_final <= cur.fin;
            run_end   <= 1'b0;
            state     <= S_TAIL;
          end
        end
        S_SCAN: begin
          if (slot_valid[idx]) begin
            slot_valid[idx] <= 1'b0;
            state           <= S_EMIT;
          end else if (idx == LAST_SLOT) begin
            state <= S_TAIL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            kind      <= K_WRITE;
            out_seq   <= rd_pkt.seq;
            out_bytes <= rd_pkt.bytes;
            out_tag   <= rd_pkt.tag;
            out_chan  <= rd_pkt.chan;
            out_final <= rd_pkt.fin;
            run_end   <= 1'b0;
            if (idx == LAST_SLOT) begin
              state <= S_TAIL;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_TAIL: begin
          if (load_ok) begin
            kind      <= tail_kind;
            run_end   <= 1'b1;
            if (tail_kind == K_DONE) begin
              out_seq   <= '0;
              out_bytes <= '0;
              out_tag   <= '0;
              out_chan  <= 1'b0;
              out_final <= 1'b0;
            end else begin
              out_seq   <= cur.seq;
              out_bytes <= cur.bytes;
              out_tag   <= cur.tag;
              out_chan  <= cur.chan;
              out_final <= cur.fin;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/srr_checker.sv =====
// Port-level checks for the stop-and-wait reorder receiver, bound to the top.
// Uses srr_pkg.
module srr_checker import srr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [KIND_W-1:0]  kind,
  input logic [SEQ_W-1:0]   out_seq,
  input logic [BYTES_W-1:0] out_bytes,
  input logic [TAG_W-1:0]   out_tag,
  input logic               run_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_seq))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_DONE |-> run_end && out_seq == '0 && out_bytes == '0
      && out_tag == '0)
    else $error("finish result carries packet fields");

  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_WRITE |-> !run_end)
    else $error("write marked as last result of an item");

  a_refuse_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_REFUSE |-> run_end)
    else $error("refusal not marked as last result");

endmodule

bind stop_and_wait_reorder_receiver srr_checker u_srr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_seq   (out_seq),
  .out_bytes (out_bytes),
  .out_tag   (out_tag),
  .run_end   (run_end)
);
